/* design/qepf_pkg.sv */
// shared types, widths and constants for the quadrant extreme point finder
package qepf_pkg;

  localparam int COORD_W = 24;
  localparam int SUM_W = 32;
  localparam int THR_W = 52;
  localparam int MAG_W = 24;
  localparam int PROD_W = 2 * MAG_W;
  localparam int DIST_W = PROD_W + 2;
  localparam int NUM_QUAD = 4;

  localparam int MAX_POINTS_DEF = 128;

  // 0.1 with 24 fraction bits
  localparam logic [THR_W-1:0] MIN_DIST_SQ_RESET = 52'd1677722;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sh800000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic              skip;
    logic [1:0]        quad;
    logic [DIST_W-1:0] dist_sq;
  } dist_res_t;

endpackage

/* design/qepf_ram.sv */
// generic single write, single read memory with registered read data
module qepf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/qepf_div.sv */
// iterative signed sum by count divider, one quotient bit a cycle, saturated result
module qepf_div #(
  parameter int CNT_W = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [qepf_pkg::SUM_W-1:0]     dividend,
  input  logic [CNT_W-1:0]               divisor,
  output logic                           done,
  output qepf_pkg::coord_t               quotient
);

  localparam int SUM_W = qepf_pkg::SUM_W;
  localparam int ITER_W = $clog2(SUM_W);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(SUM_W - 1);
  localparam logic [SUM_W-1:0] NEG_LIMIT = SUM_W'(32'h0080_0000);
  localparam logic [SUM_W-1:0] POS_LIMIT = SUM_W'(32'h007F_FFFF);

  logic              active;
  logic              finish;
  logic [ITER_W-1:0] bit_cnt;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic              neg;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              take;

  assign trial = {rem, quo[SUM_W-1]};
  assign diff = trial - {1'b0, dvs};
  assign take = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      finish <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && bit_cnt == ITER_LAST) begin
        active <= 1'b0;
        finish <= 1'b1;
      end else if (finish) begin
        finish <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dvs <= divisor;
      bit_cnt <= '0;
    end else if (active) begin
      bit_cnt <= bit_cnt + 1'b1;
      if (take) begin
        rem <= diff[CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
    if (finish) begin
      // empty set reads as zero, otherwise truncate toward zero and clamp
      if (dvs == '0) begin
        quotient <= '0;
      end else if (neg) begin
        if (quo > NEG_LIMIT) begin
          quotient <= qepf_pkg::COORD_MIN;
        end else begin
          quotient <= -$signed(quo[qepf_pkg::COORD_W-1:0]);
        end
      end else begin
        if (quo > POS_LIMIT) begin
          quotient <= qepf_pkg::COORD_MAX;
        end else begin
          quotient <= $signed(quo[qepf_pkg::COORD_W-1:0]);
        end
      end
    end
  end

endmodule

/* design/qepf_dist.sv */
// squared distance unit: one shared multiplier, three squares accumulated
module qepf_dist (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  qepf_pkg::coord_t    px,
  input  qepf_pkg::coord_t    py,
  input  qepf_pkg::coord_t    pz,
  input  qepf_pkg::coord_t    cx,
  input  qepf_pkg::coord_t    cy,
  input  qepf_pkg::coord_t    cz,
  output logic                done,
  output qepf_pkg::dist_res_t res
);

  localparam int MAG_W = qepf_pkg::MAG_W;
  localparam int PROD_W = qepf_pkg::PROD_W;
  localparam int DIST_W = qepf_pkg::DIST_W;
  localparam logic [1:0] STEP_LAST = 2'd3;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W:0] d);
    logic signed [MAG_W:0] a;
    begin
      a = d[MAG_W] ? -d : d;
      return a[MAG_W-1:0];
    end
  endfunction

  logic signed [MAG_W:0] dx;
  logic signed [MAG_W:0] dy;
  logic signed [MAG_W:0] dz;
  logic                  active;
  logic [1:0]            step;
  logic [MAG_W-1:0]      mag [3];
  logic [PROD_W-1:0]     prod;
  logic [DIST_W-1:0]     acc;
  logic [1:0]            quad;
  logic                  skip;

  assign dx = {px[MAG_W-1], px} - {cx[MAG_W-1], cx};
  assign dy = {py[MAG_W-1], py} - {cy[MAG_W-1], cy};
  assign dz = {pz[MAG_W-1], pz} - {cz[MAG_W-1], cz};

  assign res.skip = skip;
  assign res.quad = quad;
  assign res.dist_sq = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && step == STEP_LAST) begin
        active <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag[0] <= mag_of(dx);
      mag[1] <= mag_of(dy);
      mag[2] <= mag_of(dz);
      // bit 0 set on the minus x side, bit 1 on the minus z side
      quad <= {!(pz > cz), !(px > cx)};
      skip <= (px == cx) || (pz == cz);
      step <= '0;
      acc <= '0;
    end else if (active) begin
      step <= step + 1'b1;
      prod <= mag[0] * mag[0];
      mag[0] <= mag[1];
      mag[1] <= mag[2];
      if (step != 2'd0) begin
        acc <= acc + DIST_W'(prod);
      end
    end
  end

endmodule

/* design/quadrant_extreme_point_finder_core.sv */
// top level of the quadrant extreme point finder
//
// Points are taken one per cycle while busy is low (start high). Each point is
// written to the point memory and added to 32-bit wrapping sums; once
// MAX_POINTS points are held, further points are dropped and the overflow flag
// of the set is raised. The item with last_point high closes the set, and busy
// then stays high while the block works: the centroid is formed by one shared
// shift-subtract divider, one quotient bit a cycle, for each of x, y and z in
// turn; then every stored point is read back and fed to a distance unit that
// squares the three offsets on one shared multiplier, one point at a time.
// After the scan the four results leave on consecutive cycles, quadrant 0 to
// 3, each marked by result_valid for one cycle; the receiver cannot stall
// them. min_distance_sq may be written at any time busy is low; the points
// memory needs no clearing after reset.
module quadrant_extreme_point_finder_core #(
  parameter int MAX_POINTS = qepf_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // item in
  input  logic                          start,
  output logic                          busy,
  input  qepf_pkg::coord_t              point_x,
  input  qepf_pkg::coord_t              point_y,
  input  qepf_pkg::coord_t              point_z,
  input  logic                          last_point,
  // threshold register
  input  logic                          cfg_wr_en,
  input  logic [qepf_pkg::THR_W-1:0]    cfg_wr_data,
  // results
  output logic                          result_valid,
  output logic [1:0]                    quadrant,
  output logic                          found,
  output qepf_pkg::coord_t              corner_x,
  output qepf_pkg::coord_t              corner_y,
  output qepf_pkg::coord_t              corner_z,
  output logic                          overflow,
  output logic                          last_corner
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int COORD_W = qepf_pkg::COORD_W;
  localparam int SUM_W = qepf_pkg::SUM_W;
  localparam int THR_W = qepf_pkg::THR_W;
  localparam int DIST_W = qepf_pkg::DIST_W;
  localparam int NUM_QUAD = qepf_pkg::NUM_QUAD;
  localparam int RAM_W = 3 * COORD_W;
  localparam logic [CW-1:0] CAPACITY = CW'(MAX_POINTS);

  // sequencer states
  localparam logic [2:0] S_LOAD      = 3'd0;
  localparam logic [2:0] S_DIV_GO    = 3'd1;
  localparam logic [2:0] S_DIV_WAIT  = 3'd2;
  localparam logic [2:0] S_SCAN_RD   = 3'd3;
  localparam logic [2:0] S_SCAN_GO   = 3'd4;
  localparam logic [2:0] S_SCAN_WAIT = 3'd5;
  localparam logic [2:0] S_EMIT      = 3'd6;

  // coordinate select for the divider
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;
  localparam logic [1:0] EMIT_LAST = 2'd3;

  logic [2:0]         state;
  logic               accept;
  logic               room;

  // set accumulation
  logic [SUM_W-1:0]   sum_x;
  logic [SUM_W-1:0]   sum_y;
  logic [SUM_W-1:0]   sum_z;
  logic [CW-1:0]      point_count;
  logic               overflow_seen;
  logic [THR_W-1:0]   min_distance_sq;

  // centroid and divider
  logic [1:0]         div_sel;
  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   div_dividend;
  qepf_pkg::coord_t   div_quotient;
  qepf_pkg::coord_t   cent_x;
  qepf_pkg::coord_t   cent_y;
  qepf_pkg::coord_t   cent_z;

  // scan
  logic [CW-1:0]      scan_idx;
  logic [RAM_W-1:0]   ram_rdata;
  logic               dist_start;
  logic               dist_done;
  qepf_pkg::dist_res_t dist_res;
  qepf_pkg::coord_t   cur_x;
  qepf_pkg::coord_t   cur_y;
  qepf_pkg::coord_t   cur_z;
  logic               better;

  // per-quadrant best; the found flags and corners shift out toward entry 0 while results leave
  logic [THR_W-1:0]   best [NUM_QUAD];
  logic               found_q [NUM_QUAD];
  qepf_pkg::coord_t   best_x [NUM_QUAD];
  qepf_pkg::coord_t   best_y [NUM_QUAD];
  qepf_pkg::coord_t   best_z [NUM_QUAD];
  logic [1:0]         emit_cnt;

  assign busy = (state != S_LOAD);
  assign accept = start && !busy;
  assign room = (point_count < CAPACITY);
  assign div_start = (state == S_DIV_GO);
  assign dist_start = (state == S_SCAN_GO);
  assign better = dist_done && !dist_res.skip &&
                  ({{(THR_W - DIST_W){1'b0}}, dist_res.dist_sq} > best[dist_res.quad]);

  always_comb begin
    case (div_sel)
      SEL_X:   div_dividend = sum_x;
      SEL_Y:   div_dividend = sum_y;
      default: div_dividend = sum_z;
    endcase
  end

  qepf_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_POINTS)
  ) u_points (
    .clk  (clk),
    .we   (accept && room),
    .waddr(point_count[AW-1:0]),
    .wdata({point_x, point_y, point_z}),
    .raddr(scan_idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  qepf_div #(
    .CNT_W(CW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (point_count),
    .done    (div_done),
    .quotient(div_quotient)
  );

  qepf_dist u_dist (
    .clk  (clk),
    .rst  (rst),
    .start(dist_start),
    .px   (ram_rdata[3*COORD_W-1:2*COORD_W]),
    .py   (ram_rdata[2*COORD_W-1:COORD_W]),
    .pz   (ram_rdata[COORD_W-1:0]),
    .cx   (cent_x),
    .cy   (cent_y),
    .cz   (cent_z),
    .done (dist_done),
    .res  (dist_res)
  );

  // sequencer and set control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
      point_count <= '0;
      overflow_seen <= 1'b0;
      min_distance_sq <= qepf_pkg::MIN_DIST_SQ_RESET;
      div_sel <= SEL_X;
      scan_idx <= '0;
      emit_cnt <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_wr_en) begin
        min_distance_sq <= cfg_wr_data;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              sum_x <= sum_x + {{(SUM_W - COORD_W){point_x[COORD_W-1]}}, point_x};
              sum_y <= sum_y + {{(SUM_W - COORD_W){point_y[COORD_W-1]}}, point_y};
              sum_z <= sum_z + {{(SUM_W - COORD_W){point_z[COORD_W-1]}}, point_z};
              point_count <= point_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
            // a dropped point still closes the set
            if (last_point) begin
              div_sel <= SEL_X;
              state <= S_DIV_GO;
            end
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (div_sel == SEL_Z) begin
              scan_idx <= '0;
              state <= S_SCAN_RD;
            end else begin
              div_sel <= div_sel + 1'b1;
              state <= S_DIV_GO;
            end
          end
        end
        S_SCAN_RD: begin
          // memory read of scan_idx is issued on this edge
          if (scan_idx == point_count) begin
            emit_cnt <= '0;
            state <= S_EMIT;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            state <= S_SCAN_GO;
          end
        end
        S_SCAN_GO: begin
          state <= S_SCAN_WAIT;
        end
        S_SCAN_WAIT: begin
          if (dist_done) begin
            state <= S_SCAN_RD;
          end
        end
        S_EMIT: begin
          result_valid <= 1'b1;
          emit_cnt <= emit_cnt + 1'b1;
          if (emit_cnt == EMIT_LAST) begin
            // set done, ready for the next one
            sum_x <= '0;
            sum_y <= '0;
            sum_z <= '0;
            point_count <= '0;
            overflow_seen <= 1'b0;
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_DIV_WAIT && div_done) begin
      case (div_sel)
        SEL_X:   cent_x <= div_quotient;
        SEL_Y:   cent_y <= div_quotient;
        default: cent_z <= div_quotient;
      endcase
      // arm the per-quadrant search with the threshold
      if (div_sel == SEL_Z) begin
        for (int q = 0; q < NUM_QUAD; q++) begin
          best[q] <= min_distance_sq;
          found_q[q] <= 1'b0;
          best_x[q] <= '0;
          best_y[q] <= '0;
          best_z[q] <= '0;
        end
      end
    end

    if (state == S_SCAN_GO) begin
      cur_x <= ram_rdata[3*COORD_W-1:2*COORD_W];
      cur_y <= ram_rdata[2*COORD_W-1:COORD_W];
      cur_z <= ram_rdata[COORD_W-1:0];
    end

    // strictly greater, so an equal later point keeps the earlier one
    if (state == S_SCAN_WAIT && better) begin
      best[dist_res.quad] <= {{(THR_W - DIST_W){1'b0}}, dist_res.dist_sq};
      found_q[dist_res.quad] <= 1'b1;
      best_x[dist_res.quad] <= cur_x;
      best_y[dist_res.quad] <= cur_y;
      best_z[dist_res.quad] <= cur_z;
    end

    if (state == S_EMIT) begin
      quadrant <= emit_cnt;
      found <= found_q[0];
      corner_x <= best_x[0];
      corner_y <= best_y[0];
      corner_z <= best_z[0];
      overflow <= overflow_seen;
      last_corner <= (emit_cnt == EMIT_LAST);
      for (int q = 0; q < NUM_QUAD - 1; q++) begin
        found_q[q] <= found_q[q + 1];
        best_x[q] <= best_x[q + 1];
        best_y[q] <= best_y[q + 1];
        best_z[q] <= best_z[q + 1];
      end
    end
  end

`ifndef SYNTHESIS
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_EMIT))
    else $error("result strobe without emit state");

  a_results_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_corner) |=> result_valid)
    else $error("gap inside the four results of a set");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    point_count <= CAPACITY)
    else $error("point count beyond capacity");

  a_dist_in_scan: assert property (@(posedge clk) disable iff (rst)
    dist_done |-> (state == S_SCAN_WAIT))
    else $error("distance result outside scan wait");

  a_last_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && last_point) |=> busy)
    else $error("busy not raised after the last point");
`endif

endmodule

/* bench/testbench.sv */
// self-checking bench for quadrant_extreme_point_finder_core: point sets in, four corners out
`timescale 1ns / 100ps

module testbench;

  localparam int THR_W = qepf_pkg::THR_W;
  localparam int SUM_W = qepf_pkg::SUM_W;
  localparam int COORD_W = qepf_pkg::COORD_W;
  localparam int NUM_QUAD = qepf_pkg::NUM_QUAD;
  localparam logic [THR_W-1:0] MIN_DIST_SQ_RESET = qepf_pkg::MIN_DIST_SQ_RESET;
  localparam logic signed [COORD_W-1:0] COORD_MAX = qepf_pkg::COORD_MAX;
  localparam logic signed [COORD_W-1:0] COORD_MIN = qepf_pkg::COORD_MIN;

  typedef qepf_pkg::coord_t coord_t;

  localparam int MAX_PTS = qepf_pkg::MAX_POINTS_DEF;
  localparam int IDLE_PCT = 6;
  // a full set is processed with nothing accepted
  localparam int QUIET_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 300;

  // quadrant codes as the block numbers them: bit 0 is x below, bit 1 is z below
  typedef enum logic [1:0] {
    QUAD_PX_PZ = 2'd0,
    QUAD_NX_PZ = 2'd1,
    QUAD_PX_NZ = 2'd2,
    QUAD_NX_NZ = 2'd3
  } quad_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } point_item_t;

  typedef struct packed {
    quad_e  quad;
    logic   found;
    coord_t x;
    coord_t y;
    coord_t z;
    logic   ovf;
    logic   lastc;
  } corner_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // item side
  logic   start = 1'b0;
  logic   busy;
  coord_t point_x = '0;
  coord_t point_y = '0;
  coord_t point_z = '0;
  logic   last_point = 1'b0;

  // threshold register
  logic             cfg_wr_en = 1'b0;
  logic [THR_W-1:0] cfg_wr_data = '0;

  // results
  logic       result_valid;
  logic [1:0] quadrant;
  logic       found;
  coord_t     corner_x;
  coord_t     corner_y;
  coord_t     corner_z;
  logic       overflow;
  logic       last_corner;

  quadrant_extreme_point_finder_core #(
    .MAX_POINTS(MAX_PTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .last_point(last_point),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .result_valid(result_valid),
    .quadrant(quadrant),
    .found(found),
    .corner_x(corner_x),
    .corner_y(corner_y),
    .corner_z(corner_z),
    .overflow(overflow),
    .last_corner(last_corner)
  );

  always #6 clk = ~clk;

  // items waiting for the driver, and corners waiting for the block
  point_item_t point_backlog[$];
  corner_t     pending_corners[$];
  int          items_queued = 0;
  int          items_taken = 0;
  logic        took_item = 1'b0;
  int          idle_pct = IDLE_PCT;
  int          errors = 0;
  int          quiet_cycles = 0;

  // mirror of the block's set state and threshold
  coord_t                  held_x [MAX_PTS];
  coord_t                  held_y [MAX_PTS];
  coord_t                  held_z [MAX_PTS];
  logic signed [SUM_W-1:0] acc_x, acc_y, acc_z;
  int                      held;
  logic                    lost_any;
  logic [THR_W-1:0]        limit_sq;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic void clear_set();
    acc_x = '0;
    acc_y = '0;
    acc_z = '0;
    held = 0;
    lost_any = 1'b0;
  endfunction

  // sum over count, truncated toward zero, clipped to the coordinate range
  function automatic longint centroid_of(logic signed [SUM_W-1:0] s, int n);
    longint c;
    if (n == 0) return 0;
    c = longint'(s) / longint'(n);
    if (c > longint'(COORD_MAX)) c = longint'(COORD_MAX);
    if (c < longint'(COORD_MIN)) c = longint'(COORD_MIN);
    return c;
  endfunction

  // take one point into the set; the closing point yields the four corners
  function automatic void absorb_point(input point_item_t p);
    longint  cen_x, cen_y, cen_z, dx, dy, dz, dist_sq;
    longint  best [NUM_QUAD];
    corner_t pick [NUM_QUAD];
    quad_e   q;
    if (held < MAX_PTS) begin
      held_x[held] = p.x;
      held_y[held] = p.y;
      held_z[held] = p.z;
      // sums wrap at 32 bits
      acc_x += {{(SUM_W-COORD_W){p.x[COORD_W-1]}}, p.x};
      acc_y += {{(SUM_W-COORD_W){p.y[COORD_W-1]}}, p.y};
      acc_z += {{(SUM_W-COORD_W){p.z[COORD_W-1]}}, p.z};
      held++;
    end else begin
      // store full: point dropped but may still close the set
      lost_any = 1'b1;
    end
    if (!p.last) return;

    cen_x = centroid_of(acc_x, held);
    cen_y = centroid_of(acc_y, held);
    cen_z = centroid_of(acc_z, held);

    for (int k = 0; k < NUM_QUAD; k++) begin
      best[k] = longint'(limit_sq);
      pick[k] = '0;
      pick[k].quad = quad_e'(k);
      pick[k].ovf = lost_any;
      pick[k].lastc = (k == NUM_QUAD - 1);
    end

    for (int i = 0; i < held; i++) begin
      // on a boundary line: belongs to no quadrant
      if (longint'(held_x[i]) == cen_x || longint'(held_z[i]) == cen_z) continue;
      q = quad_e'({longint'(held_z[i]) < cen_z, longint'(held_x[i]) < cen_x});
      dx = longint'(held_x[i]) - cen_x;
      dy = longint'(held_y[i]) - cen_y;
      dz = longint'(held_z[i]) - cen_z;
      dist_sq = dx * dx + dy * dy + dz * dz;
      // strict compare: the threshold must be beaten, and an equal later point loses
      if (dist_sq > best[q]) begin
        best[q] = dist_sq;
        pick[q].found = 1'b1;
        pick[q].x = held_x[i];
        pick[q].y = held_y[i];
        pick[q].z = held_z[i];
      end
    end

    for (int k = 0; k < NUM_QUAD; k++)
      pending_corners.insert(pending_corners.size(), pick[k]);
    clear_set();
  endfunction

  // driver: new item at the falling edge once the previous one was taken
  always @(negedge clk) begin : drive
    point_item_t nxt;
    if (!rst && (!start || took_item)) begin
      if (point_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = point_backlog.pop_front();
        start <= 1'b1;
        point_x <= nxt.x;
        point_y <= nxt.y;
        point_z <= nxt.z;
        last_point <= nxt.last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check corners, track threshold writes, feed taken items to the predictor
  always @(posedge clk) begin : observe
    corner_t     want;
    point_item_t seen;
    if (rst) begin
      clear_set();
      limit_sq = MIN_DIST_SQ_RESET;
      took_item <= 1'b0;
      items_taken <= 0;
    end else begin
      if (result_valid) begin
        if (pending_corners.size() == 0) begin
          report_mismatch("corner with none outstanding, quadrant", longint'(quadrant), -1);
        end else begin
          want = pending_corners.pop_front();
          if (quadrant !== want.quad)
            report_mismatch("quadrant", longint'(quadrant), longint'(want.quad));
          if (found !== want.found)
            report_mismatch("found", longint'(found), longint'(want.found));
          if (corner_x !== want.x)
            report_mismatch("corner_x", longint'(corner_x), longint'(want.x));
          if (corner_y !== want.y)
            report_mismatch("corner_y", longint'(corner_y), longint'(want.y));
          if (corner_z !== want.z)
            report_mismatch("corner_z", longint'(corner_z), longint'(want.z));
          if (overflow !== want.ovf)
            report_mismatch("overflow", longint'(overflow), longint'(want.ovf));
          if (last_corner !== want.lastc)
            report_mismatch("last_corner", longint'(last_corner), longint'(want.lastc));
        end
      end
      if (cfg_wr_en) limit_sq = cfg_wr_data;
      took_item <= start && !busy;
      if (start && !busy) begin
        seen.x = point_x;
        seen.y = point_y;
        seen.z = point_z;
        seen.last = last_point;
        absorb_point(seen);
        items_taken <= items_taken + 1;
      end
    end
  end

  // watchdog: too long with neither an item nor a corner moving
  always @(posedge clk) begin
    if (rst || result_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_point(input coord_t x, y, z, input logic last);
    point_item_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.last = last;
    point_backlog.insert(point_backlog.size(), p);
    items_queued++;
  endfunction

  // uniform value in [-2^sc, 2^sc - 1]
  function automatic longint rand_coord(int sc);
    return longint'($urandom_range(0, (2 ** (sc + 1)) - 1)) - (longint'(1) << sc);
  endfunction

  function automatic point_item_t mk_point(longint x, y, z);
    point_item_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    p.z = coord_t'(z);
    p.last = 1'b0;
    return p;
  endfunction

  // one random set of npts points, the last one marked
  function automatic void queue_random_set(int npts);
    point_item_t pts[$];
    point_item_t tmp;
    int          sc, j;
    longint      cx, cy, cz, vx, vy, vz;
    if (npts < 2 || $urandom_range(1) == 0) begin
      // scattered cloud at one magnitude, full range now and then
      sc = $urandom_range(23);
      for (int i = 0; i < npts; i++)
        pts.insert(pts.size(), mk_point(rand_coord(sc), rand_coord(sc), rand_coord(sc)));
    end else begin
      // mirrored cloud: the centroid is the chosen center exactly, so boundary
      // points and equal-distance pairs land where intended
      sc = $urandom_range(21);
      cx = rand_coord(21);
      cy = rand_coord(21);
      cz = rand_coord(21);
      while (pts.size() + 1 < npts) begin
        vx = rand_coord(sc);
        vy = rand_coord(sc);
        vz = rand_coord(sc);
        case ($urandom_range(3))
          0: begin
            // x on the centroid line
            pts.insert(pts.size(), mk_point(cx, cy + vy, cz + vz));
            pts.insert(pts.size(), mk_point(cx, cy - vy, cz - vz));
          end
          1: begin
            // z on the centroid line
            pts.insert(pts.size(), mk_point(cx + vx, cy + vy, cz));
            pts.insert(pts.size(), mk_point(cx - vx, cy - vy, cz));
          end
          2: begin
            // swapped x and z give the same distance
            pts.insert(pts.size(), mk_point(cx + vx, cy + vy, cz + vz));
            pts.insert(pts.size(), mk_point(cx - vx, cy - vy, cz - vz));
            if (pts.size() + 2 <= npts) begin
              pts.insert(pts.size(), mk_point(cx + vz, cy + vy, cz + vx));
              pts.insert(pts.size(), mk_point(cx - vz, cy - vy, cz - vx));
            end
          end
          default: begin
            pts.insert(pts.size(), mk_point(cx + vx, cy + vy, cz + vz));
            pts.insert(pts.size(), mk_point(cx - vx, cy - vy, cz - vz));
          end
        endcase
      end
      // odd count: the center itself keeps the balance
      if (pts.size() < npts) pts.insert(pts.size(), mk_point(cx, cy, cz));
    end
    for (int i = pts.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = pts[i];
      pts[i] = pts[j];
      pts[j] = tmp;
    end
    foreach (pts[i]) queue_point(pts[i].x, pts[i].y, pts[i].z, i == pts.size() - 1);
  endfunction

  // all items taken, all corners seen, block idle
  task automatic wait_drained();
    do @(negedge clk);
    while (items_taken != items_queued || pending_corners.size() != 0 || busy);
  endtask

  task automatic write_limit(logic [THR_W-1:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk) cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int               n, phase_items;
    logic [THR_W-1:0] thr;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // directed sets under the reset threshold
    // lone point: it is its own centroid, so nothing qualifies
    queue_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
    // coordinate extremes, one per quadrant
    queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    queue_point(COORD_MAX, COORD_MIN, COORD_MIN, 1'b0);
    queue_point(COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);
    // two points sit on the x boundary and must be skipped
    queue_point(4096, 0, 4096, 1'b0);
    queue_point(-4096, 0, -4096, 1'b0);
    queue_point(0, 100, 8192, 1'b0);
    queue_point(0, 0, -8192, 1'b1);
    // equal distances in one quadrant: the earlier point stays
    queue_point(8192, 0, 4096, 1'b0);
    queue_point(4096, 0, 8192, 1'b0);
    queue_point(-8192, 0, -4096, 1'b0);
    queue_point(-4096, 0, -8192, 1'b1);
    // too close to the centroid to beat 0.1
    queue_point(1, 0, 1, 1'b0);
    queue_point(-1, 0, -1, 1'b1);

    // zero threshold: any off-center point wins; odd sums truncate toward zero
    write_limit('0);
    queue_point(-5, 0, 7, 1'b0);
    queue_point(0, 0, 0, 1'b1);
    queue_point(4096, 0, 4096, 1'b0);
    queue_point(-4096, 0, -4096, 1'b1);

    // distance exactly equal to the threshold does not count
    write_limit(THR_W'(1) << 25);
    queue_point(4096, 0, 4096, 1'b0);
    queue_point(-4096, 0, -4096, 1'b1);

    // one below that, it does
    write_limit((THR_W'(1) << 25) - 1);
    queue_point(4096, 0, 4096, 1'b0);
    queue_point(-4096, 0, -4096, 1'b1);

    // largest threshold: nothing can beat it
    write_limit({THR_W{1'b1}});
    queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);

    // random sets, a fresh threshold per phase
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: thr = MIN_DIST_SQ_RESET;
        2: thr = '0;
        default: thr = THR_W'({$urandom, $urandom} >> $urandom_range(12, 63));
      endcase
      write_limit(thr);
      // one phase runs back to back with no gaps
      idle_pct = (ph == 4) ? 0 : IDLE_PCT;
      // overrun the store; the dropped last point still closes the set
      if (ph == 3) queue_random_set(MAX_PTS + $urandom_range(1, 3));
      phase_items = 0;
      while (phase_items < 25) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
        queue_random_set(n);
        phase_items += n;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
